// ----- sv/swdtw_pkg.sv -----
// Shared definitions for the sliding window DTW matcher.
// Opcodes, configuration indexes, defaults and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package swdtw_pkg;

  // Default sizes handed down as top-level parameter defaults.
  localparam int DEF_MAX_WINDOW   = 64;
  localparam int DEF_MAX_TEMPLATE = 64;
  localparam int DEF_MAX_COEFFS   = 16;

  // Register reset values before clamping.
  localparam int WINDOW_RST   = 64;
  localparam int TEMPLATE_RST = 64;
  localparam int COEFFS_RST   = 13;

  // Input beat opcodes; the last code is unused and ignored.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Configuration register indexes; the last index has no register.
  localparam logic [1:0] CFG_WINDOW   = 2'd0;
  localparam logic [1:0] CFG_TEMPLATE = 2'd1;
  localparam logic [1:0] CFG_COEFFS   = 2'd2;
  localparam logic [1:0] CFG_NONE     = 2'd3;

  localparam logic [19:0] DIST_MAX = 20'hFFFFF;
  localparam logic [31:0] COST_MAX = 32'hFFFFFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_wr;
    logic push_start;
    logic push_wr;
    logic q_start;
    logic q_wr;
    logic res_push;
  } swdtw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_t;
    logic last_cell;
    logic n_zero;
  } swdtw_sts_t;

endpackage

// ----- sv/swdtw_in_if.sv -----
// Input channel of the matcher: valid, ready and the input beat fields.
// No dependencies.
`timescale 1ns / 1ps

interface swdtw_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] coefficient_value;
  logic [5:0]         template_frame_index;
  logic [3:0]         template_coeff_index;

  modport source (output valid, opcode, coefficient_value, template_frame_index,
                  template_coeff_index, input ready);
  modport sink (input valid, opcode, coefficient_value, template_frame_index,
                template_coeff_index, output ready);
endinterface

// ----- sv/swdtw_out_if.sv -----
// Output channel of the matcher: valid, ready and the result beat fields.
// No dependencies.
`timescale 1ns / 1ps

interface swdtw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] match_cost;
  logic        window_full;

  modport source (output valid, match_cost, window_full, input ready);
  modport sink (input valid, match_cost, window_full, output ready);
endinterface

// ----- sv/swdtw_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module swdtw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- sv/swdtw_ctrl.sv -----
// Controller state machine of the matcher: handshakes and command sequencing.
// Depends on swdtw_pkg.
`timescale 1ns / 1ps

module swdtw_ctrl
  import swdtw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_opcode_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  swdtw_sts_t sts_i,
  output swdtw_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRD  = 3'd1;
  localparam logic [2:0] ST_PWR  = 3'd2;
  localparam logic [2:0] ST_QRD  = 3'd3;
  localparam logic [2:0] ST_QWR  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_opcode_i)
            OP_LOAD: cmd_o.load_wr = 1'b1;
            OP_PUSH: begin
              cmd_o.push_start = 1'b1;
              state_d          = ST_PRD;
            end
            OP_QUERY: begin
              cmd_o.q_start = 1'b1;
              state_d       = sts_i.n_zero ? ST_DONE : ST_QRD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_PRD: state_d = ST_PWR;
      ST_PWR: begin
        cmd_o.push_wr = 1'b1;
        state_d       = sts_i.last_t ? ST_IDLE : ST_PRD;
      end
      ST_QRD: state_d = ST_QWR;
      ST_QWR: begin
        cmd_o.q_wr = 1'b1;
        state_d    = sts_i.last_cell ? ST_DONE : ST_QRD;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_push = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- sv/swdtw_dp.sv -----
// Datapath of the matcher: configuration, stream counters, template store,
// accumulators, distance ring, cost row and the DTW cell. Depends on
// swdtw_pkg and swdtw_ram.
`timescale 1ns / 1ps

module swdtw_dp
  import swdtw_pkg::*;
#(
  parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
  parameter int MAX_TEMPLATE = DEF_MAX_TEMPLATE,
  parameter int MAX_COEFFS   = DEF_MAX_COEFFS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swdtw_cmd_t         cmd_i,
  output swdtw_sts_t         sts_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  input  logic signed [15:0] coefficient_value_i,
  input  logic [5:0]         template_frame_index_i,
  input  logic [3:0]         template_coeff_index_i,
  output logic [31:0]        match_cost_o,
  output logic               window_full_o
);

  localparam int WCW = $clog2(MAX_WINDOW + 1);
  localparam int TCW = $clog2(MAX_TEMPLATE + 1);
  localparam int CCW = $clog2(MAX_COEFFS + 1);
  localparam int WIW = $clog2(MAX_WINDOW);
  localparam int TIW = $clog2(MAX_TEMPLATE);
  localparam int CIW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
  localparam int TAW = $clog2(MAX_TEMPLATE * MAX_COEFFS);
  localparam int DAW = $clog2(MAX_WINDOW * MAX_TEMPLATE);
  localparam int WF_RST  = (WINDOW_RST > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RST;
  localparam int TF_RST  = (TEMPLATE_RST > MAX_TEMPLATE) ? MAX_TEMPLATE : TEMPLATE_RST;
  localparam int CPF_RST = (COEFFS_RST > MAX_COEFFS) ? MAX_COEFFS : COEFFS_RST;

  logic [WCW-1:0] wf_q, fp_q;
  logic [TCW-1:0] tf_q;
  logic [CCW-1:0] cpf_q;
  logic [CIW-1:0] cc_q;
  logic [WIW-1:0] rp_q, i_q, r_q;
  logic [TIW-1:0] t_q, j_q;
  logic signed [15:0] x_q;
  logic [31:0] left_q, diag_q, work_q, match_q;
  logic        full_q, wfull_q;

  logic [15:0] tmpl_rdata;
  logic [19:0] acc_rdata, ring_rdata;
  logic [31:0] row_rdata;
  logic        tmpl_we, acc_we, ring_we, last_coef, full, last_j, last_i;
  logic [TAW-1:0] tmpl_waddr, tmpl_raddr;
  logic [DAW-1:0] ring_waddr, ring_raddr;
  logic [9:0]  cfg_v7, cfg_v5, cfg_wf, cfg_tf, cfg_cpf;
  logic signed [16:0] diff;
  logic [16:0] absd;
  logic [20:0] acc_sum;
  logic [19:0] acc_new;
  logic [31:0] m, cost;
  logic [32:0] cost_sum;

  // Configuration clamping.
  assign cfg_v7  = {3'b0, cfg_data_i};
  assign cfg_v5  = {5'b0, cfg_data_i[4:0]};
  assign cfg_wf  = (cfg_v7 < 10'd2) ? 10'd2 :
                   (cfg_v7 > 10'(MAX_WINDOW)) ? 10'(MAX_WINDOW) : cfg_v7;
  assign cfg_tf  = (cfg_v7 < 10'd2) ? 10'd2 :
                   (cfg_v7 > 10'(MAX_TEMPLATE)) ? 10'(MAX_TEMPLATE) : cfg_v7;
  assign cfg_cpf = (cfg_v5 < 10'd1) ? 10'd1 :
                   (cfg_v5 > 10'(MAX_COEFFS)) ? 10'(MAX_COEFFS) : cfg_v5;

  // Template store: loads write, pushes read per template frame.
  assign tmpl_we = cmd_i.load_wr
                && (int'(template_frame_index_i) < MAX_TEMPLATE)
                && (int'(template_coeff_index_i) < MAX_COEFFS);
  assign tmpl_waddr = TAW'(int'(template_frame_index_i) * MAX_COEFFS
                         + int'(template_coeff_index_i));
  assign tmpl_raddr = TAW'(int'(t_q) * MAX_COEFFS + int'(cc_q));

  swdtw_ram #(.WIDTH(16), .DEPTH(MAX_TEMPLATE * MAX_COEFFS)) u_tmpl (
    .clk_i   (clk_i),
    .we_i    (tmpl_we),
    .waddr_i (tmpl_waddr),
    .wdata_i (coefficient_value_i),
    .raddr_i (tmpl_raddr),
    .rdata_o (tmpl_rdata)
  );

  // Per-template distance accumulation; the first coefficient starts from zero.
  assign last_coef = (int'(cc_q) + 1 == int'(cpf_q));
  assign diff      = 17'(x_q) - 17'($signed(tmpl_rdata));
  assign absd      = diff[16] ? 17'(-diff) : 17'(diff);
  assign acc_sum   = ((cc_q == '0) ? 21'd0 : {1'b0, acc_rdata}) + {4'b0, absd};
  assign acc_new   = acc_sum[20] ? DIST_MAX : acc_sum[19:0];
  assign acc_we    = cmd_i.push_wr && !last_coef;
  assign ring_we   = cmd_i.push_wr && last_coef;

  swdtw_ram #(.WIDTH(20), .DEPTH(MAX_TEMPLATE)) u_acc (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (t_q),
    .wdata_i (acc_new),
    .raddr_i (t_q),
    .rdata_o (acc_rdata)
  );

  // Distance ring, one row of template distances per frame.
  assign ring_waddr = DAW'(int'(rp_q) * MAX_TEMPLATE + int'(t_q));
  assign ring_raddr = DAW'(int'(r_q) * MAX_TEMPLATE + int'(j_q));

  swdtw_ram #(.WIDTH(20), .DEPTH(MAX_WINDOW * MAX_TEMPLATE)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (acc_new),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  // Single cost row: entry j holds the previous row until cell j overwrites it.
  swdtw_ram #(.WIDTH(32), .DEPTH(MAX_TEMPLATE)) u_row (
    .clk_i   (clk_i),
    .we_i    (cmd_i.q_wr),
    .waddr_i (j_q),
    .wdata_i (cost),
    .raddr_i (j_q),
    .rdata_o (row_rdata)
  );

  // DTW cell: minimum of left, up and diagonal, then saturating add.
  always_comb begin
    if (j_q == '0) begin
      m = (i_q == '0) ? 32'd0 : row_rdata;
    end else begin
      m = left_q;
      if (i_q != '0) begin
        if (row_rdata < m) m = row_rdata;
        if (diag_q < m) m = diag_q;
      end
    end
  end
  assign cost_sum = {1'b0, m} + {13'b0, ring_rdata};
  assign cost     = cost_sum[32] ? COST_MAX : cost_sum[31:0];

  assign full   = (fp_q >= wf_q);
  assign last_j = (int'(j_q) + 1 == int'(tf_q));
  assign last_i = (int'(i_q) + 1 == int'(fp_q));

  assign sts_o.last_t    = (int'(t_q) + 1 == int'(tf_q));
  assign sts_o.last_cell = last_j && last_i;
  assign sts_o.n_zero    = (fp_q == '0);

  // Configuration and stream state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wf_q  <= WCW'(WF_RST);
      tf_q  <= TCW'(TF_RST);
      cpf_q <= CCW'(CPF_RST);
      cc_q  <= '0;
      rp_q  <= '0;
      fp_q  <= '0;
      t_q   <= '0;
      i_q   <= '0;
      j_q   <= '0;
      r_q   <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i != CFG_NONE) begin
        case (cfg_index_i)
          CFG_WINDOW:   wf_q  <= WCW'(cfg_wf);
          CFG_TEMPLATE: tf_q  <= TCW'(cfg_tf);
          CFG_COEFFS:   cpf_q <= CCW'(cfg_cpf);
          default:      wf_q  <= wf_q;
        endcase
        cc_q <= '0;
        rp_q <= '0;
        fp_q <= '0;
      end
      if (cmd_i.push_start) begin
        t_q <= '0;
      end
      if (cmd_i.push_wr) begin
        if (sts_o.last_t) begin
          t_q <= '0;
          if (last_coef) begin
            cc_q <= '0;
            rp_q <= (int'(rp_q) + 1 >= int'(wf_q)) ? '0 : rp_q + 1'b1;
            if (fp_q < wf_q) fp_q <= fp_q + 1'b1;
          end else begin
            cc_q <= cc_q + 1'b1;
          end
        end else begin
          t_q <= t_q + 1'b1;
        end
      end
      if (cmd_i.q_start) begin
        i_q <= '0;
        j_q <= '0;
        r_q <= full ? rp_q : '0;
      end
      if (cmd_i.q_wr) begin
        if (last_j) begin
          j_q <= '0;
          i_q <= i_q + 1'b1;
          r_q <= (int'(r_q) + 1 >= int'(wf_q)) ? '0 : r_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
    end
  end

  // Payload registers: pushed coefficient, cell neighbors and results.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_start) x_q <= coefficient_value_i;
    if (cmd_i.q_start) begin
      work_q <= COST_MAX;
      full_q <= full;
    end
    if (cmd_i.q_wr) begin
      left_q <= cost;
      diag_q <= row_rdata;
      work_q <= cost;
    end
    if (cmd_i.res_push) begin
      match_q <= work_q;
      wfull_q <= full_q;
    end
  end

  assign match_cost_o  = match_q;
  assign window_full_o = wfull_q;

endmodule

// ----- sv/sliding_window_dtw_matcher.sv -----
// Sliding window DTW matcher, L1 frame distance, top level.
// A load is written as it is accepted. A push runs a read state and a write
// state per template frame, a query the same pair per DTW cell; a query with
// no complete frame goes straight to the result.
// One beat is in work at a time; a result waits in the output register.
// Reset (rst_ni, asynchronous, active low) clears counters and loads defaults.
`timescale 1ns / 1ps

module sliding_window_dtw_matcher
  import swdtw_pkg::*;
#(
  parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
  parameter int MAX_TEMPLATE = DEF_MAX_TEMPLATE,
  parameter int MAX_COEFFS   = DEF_MAX_COEFFS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  swdtw_in_if.sink    in_i,
  swdtw_out_if.source out_o
);

  swdtw_cmd_t cmd;
  swdtw_sts_t sts;

  // Controller.
  swdtw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  swdtw_dp #(
    .MAX_WINDOW   (MAX_WINDOW),
    .MAX_TEMPLATE (MAX_TEMPLATE),
    .MAX_COEFFS   (MAX_COEFFS)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .cfg_we_i               (cfg_we_i),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .coefficient_value_i    (in_i.coefficient_value),
    .template_frame_index_i (in_i.template_frame_index),
    .template_coeff_index_i (in_i.template_coeff_index),
    .match_cost_o           (out_o.match_cost),
    .window_full_o          (out_o.window_full)
  );

  // No new beat is taken while a push or a DTW cell is being computed.
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.q_wr || cmd.push_wr) |-> !in_i.ready)
    else $error("input ready while computing");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_push |-> (!out_o.valid || out_o.ready))
    else $error("result overwritten");

  // Each cell write is preceded by its read cycle.
  a_cell_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.q_wr |=> !cmd.q_wr)
    else $error("back-to-back cell writes");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the sliding window DTW matcher.
// Depends on swdtw_pkg, swdtw_in_if, swdtw_out_if and sliding_window_dtw_matcher.
// An in-bench predictor computes the expected cost of each query beat.
`timescale 1ns / 1ps

module tb;
  import swdtw_pkg::*;

  typedef struct packed {
    logic [31:0] cost;
    logic        full;
  } match_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [6:0] cfg_data_i;

  swdtw_in_if  in_ch ();
  swdtw_out_if out_ch ();

  sliding_window_dtw_matcher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Predictor state, mirroring the block.
  logic signed [15:0] tmpl_mem [64][16];
  logic [19:0]        frame_acc [64];
  logic [19:0]        dist_ring [64][64];
  int unsigned        ring_pos, coef_cnt, frames_seen;
  int unsigned        win_len, tmpl_len, coef_len;

  match_t      pending_matches[$];
  int unsigned mismatches;
  int unsigned send_gap_max;
  int unsigned stall_max;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #50000000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
                                        input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clear_stream();
    for (int t = 0; t < 64; t++) frame_acc[t] = '0;
    ring_pos    = 0;
    coef_cnt    = 0;
    frames_seen = 0;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? COST_MAX : s[31:0];
  endfunction

  // Accumulate one coefficient against every template frame; close the frame when complete.
  function automatic void predict_push(input logic signed [15:0] x);
    int          d;
    logic [20:0] s;
    for (int t = 0; t < tmpl_len; t++) begin
      d = int'(x) - int'(tmpl_mem[t][coef_cnt]);
      if (d < 0) d = -d;
      s = {1'b0, frame_acc[t]} + 21'(d);
      frame_acc[t] = (s > 21'(DIST_MAX)) ? DIST_MAX : s[19:0];
    end
    coef_cnt++;
    if (coef_cnt < coef_len) return;
    coef_cnt = 0;
    for (int t = 0; t < tmpl_len; t++) begin
      dist_ring[ring_pos][t] = frame_acc[t];
      frame_acc[t] = '0;
    end
    ring_pos++;
    if (ring_pos >= win_len) ring_pos = 0;
    if (frames_seen < win_len) frames_seen++;
  endfunction

  // Warp the window, oldest frame first, against the template.
  function automatic logic [31:0] predict_cost();
    logic [31:0] prev_row [64];
    logic [31:0] cur_row [64];
    logic [31:0] m;
    int unsigned oldest, r;
    if (frames_seen == 0) return COST_MAX;
    oldest = (frames_seen >= win_len) ? ring_pos : 0;
    for (int i = 0; i < frames_seen; i++) begin
      r = oldest + i;
      if (r >= win_len) r -= win_len;
      cur_row[0] = sat_add((i == 0) ? 32'd0 : prev_row[0], 32'(dist_ring[r][0]));
      for (int j = 1; j < tmpl_len; j++) begin
        m = cur_row[j-1];
        if (i > 0) begin
          if (prev_row[j] < m) m = prev_row[j];
          if (prev_row[j-1] < m) m = prev_row[j-1];
        end
        cur_row[j] = sat_add(m, 32'(dist_ring[r][j]));
      end
      prev_row = cur_row;
    end
    return cur_row[tmpl_len-1];
  endfunction

  // Send one beat; returns at the edge where it is accepted, valid still high.
  task automatic send_beat(input logic [1:0] op, input logic signed [15:0] val,
                           input logic [5:0] frame, input logic [3:0] coef);
    int unsigned gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid                <= 1'b1;
    in_ch.opcode               <= op;
    in_ch.coefficient_value    <= val;
    in_ch.template_frame_index <= frame;
    in_ch.template_coeff_index <= coef;
    do @(negedge clk_i); while (!in_ch.ready);
    @(posedge clk_i);
    case (op)
      OP_LOAD:  tmpl_mem[frame][coef] = val;
      OP_PUSH:  predict_push(val);
      OP_QUERY: pending_matches.push_back('{predict_cost(), frames_seen >= win_len});
      default: ;
    endcase
  endtask

  // Wait until every result is back, then let a push still in work finish.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WINDOW:   win_len  = clamp(val, 2, 64);
      CFG_TEMPLATE: tmpl_len = clamp(val, 2, 64);
      CFG_COEFFS:   coef_len = clamp(val[4:0], 1, 16);
      default: return;
    endcase
    clear_stream();
  endtask

  task automatic set_config(input logic [6:0] w, input logic [6:0] t, input logic [6:0] c);
    write_reg(CFG_WINDOW, w);
    write_reg(CFG_TEMPLATE, t);
    write_reg(CFG_COEFFS, c);
  endtask

  task automatic push_random();
    send_beat(OP_PUSH, 16'($urandom), 6'($urandom), 4'($urandom));
  endtask

  // Receiver: random stalls per result, checked at the falling edge before the accepting edge.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(stall_max, 0);
      out_ch.ready <= (stall == 0);
      if (stall > 0) begin
        repeat (stall) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end
      do @(negedge clk_i); while (!out_ch.valid);
      if (pending_matches.size() == 0) begin
        report("result beat with no query outstanding");
      end else begin
        match_t want;
        want = pending_matches.pop_front();
        if (out_ch.match_cost !== want.cost)
          report($sformatf("match_cost %0h, expected %0h", out_ch.match_cost, want.cost));
        if (out_ch.window_full !== want.full)
          report($sformatf("window_full %0b, expected %0b", out_ch.window_full, want.full));
      end
      @(posedge clk_i);
    end
  end

  // Queries before any complete frame, then load every template entry the tests read:
  // coefficient 0 of all frames, the first four coefficients of the first twelve
  // frames and all coefficients of the first two frames.
  task automatic test_empty_and_template();
    send_beat(OP_QUERY, 16'sd0, 6'd0, 4'd0);
    send_beat(OP_NONE, 16'sh7FFF, 6'd63, 4'd15);
    send_gap_max = 0;
    for (int f = 0; f < 64; f++)
      for (int c = 0; c < 16; c++)
        if (c == 0 || f < 2 || (f < 12 && c < 4))
          send_beat(OP_LOAD, (f == 0) ? 16'sh8000 : (f == 1) ? 16'sh7FFF : 16'($urandom),
                    6'(f), 4'(c));
    send_gap_max = 19;
  endtask

  // Extreme coefficients, a frame in progress, partial and full windows.
  task automatic test_directed();
    set_config(7'd3, 7'd3, 7'd2);
    send_beat(OP_PUSH, 16'sh7FFF, 6'd0, 4'd0);
    send_beat(OP_QUERY, 16'sd0, 6'd0, 4'd0);
    send_beat(OP_PUSH, 16'sh8000, 6'd0, 4'd0);
    send_beat(OP_QUERY, 16'sd0, 6'd0, 4'd0);
    for (int k = 0; k < 6; k++)
      send_beat(OP_PUSH, (k[0]) ? 16'sh8000 : 16'sh7FFF, 6'd0, 4'd0);
    send_beat(OP_QUERY, 16'sd0, 6'd0, 4'd0);
    send_beat(OP_NONE, 16'sd0, 6'd0, 4'd0);
    send_beat(OP_LOAD, 16'sh8000, 6'd2, 4'd1);
    push_random();
    push_random();
    send_beat(OP_QUERY, 16'sd0, 6'd0, 4'd0);
  endtask

  // Register values below and above the legal ranges, and the unused index.
  task automatic test_config_extremes();
    set_config(7'd0, 7'd127, 7'd0);
    repeat (5) push_random();
    send_beat(OP_QUERY, 16'sd0, 6'd0, 4'd0);
    set_config(7'd127, 7'd1, 7'd31);
    repeat (20) push_random();
    send_beat(OP_QUERY, 16'sd0, 6'd0, 4'd0);
    write_reg(CFG_NONE, 7'h55);
    send_beat(OP_QUERY, 16'sd0, 6'd0, 4'd0);
  endtask

  // Random phases; mostly small sizes, one phase at the largest window.
  task automatic test_random();
    int unsigned pick;
    for (int p = 0; p < 6; p++) begin
      if (p == 5) set_config(7'd64, 7'd12, 7'd1);
      else set_config(7'($urandom_range(12, 2)), 7'($urandom_range(12, 2)),
                      7'($urandom_range(4, 1)));
      stall_max    = (p == 2) ? 0 : 19;
      send_gap_max = (p == 3) ? 0 : 19;
      for (int k = 0; k < ((p == 5) ? 30 : 40); k++) begin
        if (p == 1 && k == 20) drain();
        pick = $urandom_range(99, 0);
        if (pick < 72)
          push_random();
        else if (pick < ((p == 5) ? 76 : 86))
          send_beat(OP_QUERY, 16'($urandom), 6'($urandom), 4'($urandom));
        else if (pick < 95)
          send_beat(OP_LOAD, 16'($urandom), 6'($urandom), 4'($urandom));
        else
          send_beat(OP_NONE, 16'($urandom), 6'($urandom), 4'($urandom));
      end
    end
  endtask

  // Main sequence.
  initial begin
    mismatches   = 0;
    send_gap_max = 19;
    stall_max    = 19;
    win_len      = WINDOW_RST;
    tmpl_len     = TEMPLATE_RST;
    coef_len     = COEFFS_RST;
    clear_stream();
    rst_ni                     = 1'b0;
    cfg_we_i                   = 1'b0;
    cfg_index_i                = CFG_WINDOW;
    cfg_data_i                 = '0;
    in_ch.valid                = 1'b0;
    in_ch.opcode               = OP_LOAD;
    in_ch.coefficient_value    = '0;
    in_ch.template_frame_index = '0;
    in_ch.template_coeff_index = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_template();
    test_directed();
    test_config_extremes();
    test_random();

    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/swdtw_pkg.sv
sv/swdtw_in_if.sv
sv/swdtw_out_if.sv
sv/swdtw_ram.sv
sv/swdtw_ctrl.sv
sv/swdtw_dp.sv
sv/sliding_window_dtw_matcher.sv
tb/tb.sv
